/* src/tvdff_pkg.sv */
package tvdff_pkg;

    // Fraction bits of the Q16.16 operands.
    localparam int FRAC_W = 16;

    // Limiter selection codes.
    localparam logic [2:0] LIM_MINMOD     = 3'd0;
    localparam logic [2:0] LIM_SUPERBEE   = 3'd1;
    localparam logic [2:0] LIM_VAN_LEER   = 3'd2;
    localparam logic [2:0] LIM_MUSCL      = 3'd3;
    localparam logic [2:0] LIM_SWEBY      = 3'd4;
    localparam logic [2:0] LIM_VAN_ALBADA = 3'd5;
    localparam logic [2:0] LIM_QUICK      = 3'd6;
    localparam logic [2:0] LIM_UMIST      = 3'd7;

    // Limiter output ceiling, 2.0 in Q16.16.
    localparam logic [17:0] PHI_CAP = 18'd131072;

    // Operands that ride along with an item after the gradient products.
    typedef struct packed {
        logic [47:0]        ddn_mag;
        logic               ddn_neg;
        logic signed [47:0] pu;
        logic [32:0]        a;
        logic [31:0]        lu;
        logic [31:0]        scale;
        logic               ds;
    } tail_t;

    // Side data through the gradient ratio divider.
    typedef struct packed {
        logic  r_neg;
        tail_t tail;
    } side_r_t;

    // Side data through the limiter divider.
    typedef struct packed {
        logic [17:0] phi_simple;
        logic        use_div;
        logic        n_neg;
        tail_t       tail;
    } side_p_t;

    // Side data through the interpolation divider.
    typedef struct packed {
        logic               t_neg;
        logic signed [47:0] pu;
        logic [31:0]        scale;
        logic               ds;
    } side_t_t;

endpackage

/* src/tvd_limited_face_flux_unit.sv */
// Channel   Handshake                 Payload
// input     in_valid / in_stall       q_far c_far q_up c_up q_down c_down len_far len_up
//                                     len_down far_is_boundary face_is_downstream scale
// output    out_valid / out_stall     face_flux flux_saturated
// config    cfg_write                 cfg_data (limiter kind)
//
// One item enters per cycle while the output is not stalled. The pipeline holds three
// bit-per-stage dividers: 32 stages for the gradient ratio, 19 for the limiter and 50 for
// the interpolation term, plus 16 arithmetic stages.
// The whole pipeline advances together; it holds only while the output item is stalled.
// Reset clears the valid bits and sets the limiter to minmod.
module tvd_limited_face_flux_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] q_far,
    input  logic signed [31:0] c_far,
    input  logic signed [31:0] q_up,
    input  logic signed [31:0] c_up,
    input  logic signed [31:0] q_down,
    input  logic signed [31:0] c_down,
    input  logic [31:0]        len_far,
    input  logic [31:0]        len_up,
    input  logic [31:0]        len_down,
    input  logic               far_is_boundary,
    input  logic               face_is_downstream,
    input  logic [31:0]        scale,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [47:0] face_flux,
    output logic               flux_saturated
);

    import tvdff_pkg::*;

    localparam logic signed [35:0] ONE_S   = 36'sd65536;
    localparam logic signed [35:0] TWO_S   = 36'sd131072;
    localparam logic signed [35:0] THREE_S = 36'sd196608;
    localparam logic signed [35:0] SWEBY_S = 36'sd98304;
    localparam logic signed [35:0] ZERO_S  = 36'sd0;

    function automatic logic signed [35:0] smax(input logic signed [35:0] x,
                                                input logic signed [35:0] y);
        smax = (x > y) ? x : y;
    endfunction

    function automatic logic signed [35:0] smin(input logic signed [35:0] x,
                                                input logic signed [35:0] y);
        smin = (x < y) ? x : y;
    endfunction

    logic [2:0] limiter_kind_reg;
    logic       adv;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limiter_kind_reg <= LIM_MINMOD;
        end
        else if (cfg_write)
        begin
            limiter_kind_reg <= cfg_data;
        end
    end

    // The pipeline moves unless a finished item waits on a stalled output.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Stage 1: cell products and gradient distances.
    logic signed [63:0] pf_prod, pu_prod, pd_prod;
    logic signed [47:0] pf1_reg, pu1_reg, pd1_reg;
    logic [32:0]        a1_next, b1_next, a1_reg, b1_reg;
    logic [31:0]        lu1_reg, scale1_reg;
    logic               ds1_reg, v1_reg;

    assign pf_prod = q_far * c_far;
    assign pu_prod = q_up * c_up;
    assign pd_prod = q_down * c_down;
    assign a1_next = {1'b0, len_up} + {1'b0, len_down};
    assign b1_next = far_is_boundary ? {1'b0, len_up} : ({1'b0, len_up} + {1'b0, len_far});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pf1_reg    <= pf_prod[63:16];
            pu1_reg    <= pu_prod[63:16];
            pd1_reg    <= pd_prod[63:16];
            a1_reg     <= a1_next;
            b1_reg     <= b1_next;
            lu1_reg    <= len_up;
            scale1_reg <= scale;
            ds1_reg    <= face_is_downstream;
        end
    end

    // Stage 2: gradients split into magnitude and sign.
    logic signed [48:0] dfar_next, ddn_next;
    logic [48:0]        dfar_abs, ddn_abs;
    logic [47:0]        dfar2_reg, ddn2_reg;
    logic               dfar_neg2_reg, ddn_neg2_reg;
    logic signed [47:0] pu2_reg;
    logic [32:0]        a2_reg, b2_reg;
    logic [31:0]        lu2_reg, scale2_reg;
    logic               ds2_reg, v2_reg;

    assign dfar_next = {pu1_reg[47], pu1_reg} - {pf1_reg[47], pf1_reg};
    assign ddn_next  = {pd1_reg[47], pd1_reg} - {pu1_reg[47], pu1_reg};
    assign dfar_abs  = dfar_next[48] ? -dfar_next : dfar_next;
    assign ddn_abs   = ddn_next[48] ? -ddn_next : ddn_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dfar2_reg     <= dfar_abs[47:0];
            ddn2_reg      <= ddn_abs[47:0];
            dfar_neg2_reg <= dfar_next[48];
            ddn_neg2_reg  <= ddn_next[48];
            pu2_reg       <= pu1_reg;
            a2_reg        <= a1_reg;
            b2_reg        <= b1_reg;
            lu2_reg       <= lu1_reg;
            scale2_reg    <= scale1_reg;
            ds2_reg       <= ds1_reg;
        end
    end

    // Stage 3: partial products of the ratio numerator and denominator.
    logic [56:0] rn_lo_next, rn_hi_next, rd_lo_next, rd_hi_next;
    logic [56:0] rn_lo3_reg, rn_hi3_reg, rd_lo3_reg, rd_hi3_reg;
    logic        r_neg3_reg;
    tail_t       tail3_reg;
    logic        v3_reg;

    assign rn_lo_next = dfar2_reg[23:0] * a2_reg;
    assign rn_hi_next = dfar2_reg[47:24] * a2_reg;
    assign rd_lo_next = ddn2_reg[23:0] * b2_reg;
    assign rd_hi_next = ddn2_reg[47:24] * b2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rn_lo3_reg        <= rn_lo_next;
            rn_hi3_reg        <= rn_hi_next;
            rd_lo3_reg        <= rd_lo_next;
            rd_hi3_reg        <= rd_hi_next;
            r_neg3_reg        <= dfar_neg2_reg != ddn_neg2_reg;
            tail3_reg.ddn_mag <= ddn2_reg;
            tail3_reg.ddn_neg <= ddn_neg2_reg;
            tail3_reg.pu      <= pu2_reg;
            tail3_reg.a       <= a2_reg;
            tail3_reg.lu      <= lu2_reg;
            tail3_reg.scale   <= scale2_reg;
            tail3_reg.ds      <= ds2_reg;
        end
    end

    // Stage 4: ratio numerator in Q.16 and denominator.
    logic [80:0] rn_sum, rd_sum;
    logic [96:0] rnum4_reg;
    logic [80:0] rden4_reg;
    side_r_t     sider4_reg;
    logic        v4_reg;

    assign rn_sum = 81'(rn_lo3_reg) + (81'(rn_hi3_reg) << 24);
    assign rd_sum = 81'(rd_lo3_reg) + (81'(rd_hi3_reg) << 24);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rnum4_reg        <= {rn_sum, 16'b0};
            rden4_reg        <= rd_sum;
            sider4_reg.r_neg <= r_neg3_reg;
            sider4_reg.tail  <= tail3_reg;
        end
    end

    // Gradient ratio divider.
    logic        vr_out;
    logic [30:0] qr_out;
    logic        ovfr_out;
    side_r_t     sider_out;

    tvdff_div #(
        .NW(97),
        .DW(81),
        .QW(31),
        .SW($bits(side_r_t))
    ) u_div_r (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .item_valid (v4_reg),
        .num        (rnum4_reg),
        .den        (rden4_reg),
        .side       (sider4_reg),
        .quo_valid  (vr_out),
        .quo        (qr_out),
        .ovf        (ovfr_out),
        .quo_side   (sider_out)
    );

    // Stage 5: signed, saturated ratio r.
    logic [31:0]        r_mag;
    logic signed [31:0] r5_reg;
    tail_t              tail5_reg;
    logic               v5_reg;

    assign r_mag = {1'b0, (ovfr_out ? 31'h7FFF_FFFF : qr_out)};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r5_reg    <= sider_out.r_neg ? -r_mag : r_mag;
            tail5_reg <= sider_out.tail;
        end
    end

    // Stage 6: piecewise limiters and r squared.
    logic signed [35:0] rx, two_r, three_r;
    logic signed [35:0] half_r1, quart_r3, quart_3r1;
    logic signed [35:0] lim_val;
    logic signed [63:0] sq_next;
    logic signed [31:0] r6_reg;
    logic [63:0]        sq6_reg;
    logic [17:0]        phi6_reg;
    tail_t              tail6_reg;
    logic               v6_reg;

    assign rx        = 36'(r5_reg);
    assign two_r     = rx <<< 1;
    assign three_r   = rx + two_r;
    assign half_r1   = (rx + ONE_S) >>> 1;
    assign quart_r3  = (THREE_S + rx) >>> 2;
    assign quart_3r1 = (ONE_S + three_r) >>> 2;
    assign sq_next   = r5_reg * r5_reg;

    always_comb
    begin
        case (limiter_kind_reg)
            LIM_MINMOD:
                lim_val = smax(ZERO_S, smin(rx, ONE_S));
            LIM_SUPERBEE:
                lim_val = smax(ZERO_S, smax(smin(two_r, ONE_S), smin(rx, TWO_S)));
            LIM_MUSCL:
                lim_val = smax(ZERO_S, smin(smin(two_r, half_r1), TWO_S));
            LIM_SWEBY:
                lim_val = smax(ZERO_S, smax(smin(three_r >>> 1, ONE_S), smin(rx, SWEBY_S)));
            LIM_QUICK:
                lim_val = smax(ZERO_S, smin(smin(two_r, quart_r3), TWO_S));
            LIM_UMIST:
                lim_val = smax(ZERO_S, smin(smin(two_r, quart_3r1), smin(quart_r3, TWO_S)));
            default:
                lim_val = ZERO_S;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r6_reg    <= r5_reg;
            sq6_reg   <= sq_next;
            phi6_reg  <= lim_val[17:0];
            tail6_reg <= tail5_reg;
        end
    end

    // Stage 7: operands of the rational limiters.
    logic signed [64:0] va_n;
    logic [64:0]        va_abs;
    logic               r_pos;
    logic [79:0]        pnum_next;
    logic [63:0]        pden_next;
    logic               use_div_next, n_neg_next;
    logic [79:0]        pnum7_reg;
    logic [63:0]        pden7_reg;
    side_p_t            sidep7_reg;
    logic               v7_reg;

    assign r_pos  = !r6_reg[31] && (r6_reg != 32'sd0);
    assign va_n   = {{17{r6_reg[31]}}, r6_reg, 16'b0} + {1'b0, sq6_reg};
    assign va_abs = va_n[64] ? -va_n : va_n;

    always_comb
    begin
        pnum_next    = '0;
        pden_next    = '0;
        use_div_next = 1'b0;
        n_neg_next   = 1'b0;
        case (limiter_kind_reg)
            LIM_VAN_LEER:
            begin
                use_div_next = 1'b1;
                if (r_pos)
                begin
                    pnum_next = 80'({r6_reg[30:0], 1'b0, 16'b0});
                    pden_next = {32'b0, r6_reg} + 64'h1_0000;
                end
            end
            LIM_VAN_ALBADA:
            begin
                use_div_next = 1'b1;
                n_neg_next   = va_n[64];
                pnum_next    = {va_abs[63:0], 16'b0};
                pden_next    = sq6_reg + 64'h1_0000_0000;
            end
            default:
            begin
                use_div_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pnum7_reg             <= pnum_next;
            pden7_reg             <= pden_next;
            sidep7_reg.phi_simple <= phi6_reg;
            sidep7_reg.use_div    <= use_div_next;
            sidep7_reg.n_neg      <= n_neg_next;
            sidep7_reg.tail       <= tail6_reg;
        end
    end

    // Limiter divider.
    logic        vp_out;
    logic [17:0] qp_out;
    logic        ovfp_out;
    side_p_t     sidep_out;

    tvdff_div #(
        .NW(80),
        .DW(64),
        .QW(18),
        .SW($bits(side_p_t))
    ) u_div_p (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .item_valid (v7_reg),
        .num        (pnum7_reg),
        .den        (pden7_reg),
        .side       (sidep7_reg),
        .quo_valid  (vp_out),
        .quo        (qp_out),
        .ovf        (ovfp_out),
        .quo_side   (sidep_out)
    );

    // Stage 8: limiter value and the sign of the interpolated term.
    logic [17:0] dphi;
    logic        phi_neg;
    logic [17:0] phi_mag8_reg;
    logic        t_neg8_reg;
    tail_t       tail8_reg;
    logic        v8_reg;

    assign dphi    = (ovfp_out || (qp_out > PHI_CAP)) ? PHI_CAP : qp_out;
    assign phi_neg = sidep_out.use_div && sidep_out.n_neg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            phi_mag8_reg <= sidep_out.use_div ? dphi : sidep_out.phi_simple;
            t_neg8_reg   <= phi_neg != sidep_out.tail.ddn_neg;
            tail8_reg    <= sidep_out.tail;
        end
    end

    // Stage 9: phi times the upwind length.
    logic [49:0] m9_next;
    logic [49:0] m9_reg;
    logic        t_neg9_reg;
    tail_t       tail9_reg;
    logic        v9_reg;

    assign m9_next = phi_mag8_reg * tail8_reg.lu;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m9_reg     <= m9_next;
            t_neg9_reg <= t_neg8_reg;
            tail9_reg  <= tail8_reg;
        end
    end

    // Stage 10: partial products with the downwind gradient.
    logic [48:0] pp_ll_next, pp_lh_next, pp_hl_next, pp_hh_next;
    logic [48:0] pp_ll10_reg, pp_lh10_reg, pp_hl10_reg, pp_hh10_reg;
    logic        t_neg10_reg;
    tail_t       tail10_reg;
    logic        v10_reg;

    assign pp_ll_next = m9_reg[24:0] * tail9_reg.ddn_mag[23:0];
    assign pp_lh_next = m9_reg[24:0] * tail9_reg.ddn_mag[47:24];
    assign pp_hl_next = m9_reg[49:25] * tail9_reg.ddn_mag[23:0];
    assign pp_hh_next = m9_reg[49:25] * tail9_reg.ddn_mag[47:24];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_ll10_reg <= pp_ll_next;
            pp_lh10_reg <= pp_lh_next;
            pp_hl10_reg <= pp_hl_next;
            pp_hh10_reg <= pp_hh_next;
            t_neg10_reg <= t_neg9_reg;
            tail10_reg  <= tail9_reg;
        end
    end

    // Stage 11: interpolation numerator and denominator.
    logic [97:0] tnum11_reg;
    logic [48:0] tden11_reg;
    side_t_t     sidet11_reg;
    logic        v11_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tnum11_reg        <= 98'(pp_ll10_reg) + (98'(pp_lh10_reg) << 24)
                                 + (98'(pp_hl10_reg) << 25) + (98'(pp_hh10_reg) << 49);
            tden11_reg        <= {tail10_reg.a, 16'b0};
            sidet11_reg.t_neg <= t_neg10_reg;
            sidet11_reg.pu    <= tail10_reg.pu;
            sidet11_reg.scale <= tail10_reg.scale;
            sidet11_reg.ds    <= tail10_reg.ds;
        end
    end

    // Interpolation divider.
    logic        vt_out;
    logic [48:0] qt_out;
    logic        ovft_out;
    side_t_t     sidet_out;

    tvdff_div #(
        .NW(98),
        .DW(49),
        .QW(49),
        .SW($bits(side_t_t))
    ) u_div_t (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .item_valid (v11_reg),
        .num        (tnum11_reg),
        .den        (tden11_reg),
        .side       (sidet11_reg),
        .quo_valid  (vt_out),
        .quo        (qt_out),
        .ovf        (ovft_out),
        .quo_side   (sidet_out)
    );

    // Stage 12: upwind value plus the limited term.
    logic [50:0]        tm_ext;
    logic signed [50:0] term;
    logic signed [50:0] f12_reg;
    logic [31:0]        scale12_reg;
    logic               ds12_reg, v12_reg;

    assign tm_ext = {2'b0, (ovft_out ? '1 : qt_out)};
    assign term   = sidet_out.t_neg ? -tm_ext : tm_ext;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f12_reg     <= {{3{sidet_out.pu[47]}}, sidet_out.pu} + term;
            scale12_reg <= sidet_out.scale;
            ds12_reg    <= sidet_out.ds;
        end
    end

    // Stage 13: magnitude of the unscaled flux.
    logic [50:0] f_abs;
    logic [49:0] fmag13_reg;
    logic        fneg13_reg;
    logic [31:0] scale13_reg;
    logic        ds13_reg, v13_reg;

    assign f_abs = f12_reg[50] ? -f12_reg : f12_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fmag13_reg  <= f_abs[49:0];
            fneg13_reg  <= f12_reg[50];
            scale13_reg <= scale12_reg;
            ds13_reg    <= ds12_reg;
        end
    end

    // Stage 14: partial products with the heat factor.
    logic [56:0] sp_lo_next, sp_hi_next;
    logic [56:0] sp_lo14_reg, sp_hi14_reg;
    logic        fneg14_reg, ds14_reg, v14_reg;

    assign sp_lo_next = fmag13_reg[24:0] * scale13_reg;
    assign sp_hi_next = fmag13_reg[49:25] * scale13_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp_lo14_reg <= sp_lo_next;
            sp_hi14_reg <= sp_hi_next;
            fneg14_reg  <= fneg13_reg;
            ds14_reg    <= ds13_reg;
        end
    end

    // Stage 15: scaled magnitude back to Q.16.
    logic [81:0] sp_sum;
    logic [65:0] fm15_reg;
    logic        fneg15_reg, ds15_reg, v15_reg;

    assign sp_sum = 82'(sp_lo14_reg) + (82'(sp_hi14_reg) << 25);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fm15_reg   <= sp_sum[81:16];
            fneg15_reg <= fneg14_reg;
            ds15_reg   <= ds14_reg;
        end
    end

    // Stage 16: sign, saturation and the output register.
    logic        res_neg, sat_next;
    logic [47:0] res_next;
    logic [47:0] face_flux_reg;
    logic        flux_saturated_reg, out_valid_reg;

    always_comb
    begin
        res_neg = (fneg15_reg != ds15_reg) && (fm15_reg != '0);
        if (res_neg)
        begin
            sat_next = fm15_reg > 66'h8000_0000_0000;
            res_next = sat_next ? 48'h8000_0000_0000 : -fm15_reg[47:0];
        end
        else
        begin
            sat_next = fm15_reg > 66'h7FFF_FFFF_FFFF;
            res_next = sat_next ? 48'h7FFF_FFFF_FFFF : fm15_reg[47:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            face_flux_reg      <= res_next;
            flux_saturated_reg <= sat_next;
        end
    end

    // Valid bits that travel with each item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            v12_reg       <= 1'b0;
            v13_reg       <= 1'b0;
            v14_reg       <= 1'b0;
            v15_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= vr_out;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            v8_reg        <= vp_out;
            v9_reg        <= v8_reg;
            v10_reg       <= v9_reg;
            v11_reg       <= v10_reg;
            v12_reg       <= vt_out;
            v13_reg       <= v12_reg;
            v14_reg       <= v13_reg;
            v15_reg       <= v14_reg;
            out_valid_reg <= v15_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign face_flux      = face_flux_reg;
    assign flux_saturated = flux_saturated_reg;

    // The limiter never goes above 2.0.
    a_phi_cap: assert property (@(posedge clk) disable iff (!rst_n)
        v8_reg |-> (phi_mag8_reg <= PHI_CAP))
        else $error("limiter value above 2.0");

    // The interpolated term always fits its quotient width.
    a_term_fit: assert property (@(posedge clk) disable iff (!rst_n)
        vt_out |-> !ovft_out)
        else $error("interpolation quotient overflow");

    // A clipped item carries one of the two range limits.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && flux_saturated_reg) |->
            ((face_flux_reg == 48'h7FFF_FFFF_FFFF) || (face_flux_reg == 48'h8000_0000_0000)))
        else $error("saturated flux not at a range limit");

endmodule

/* src/tvdff_div.sv */
module tvdff_div #(
    parameter int NW = 97,
    parameter int DW = 81,
    parameter int QW = 31,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          item_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          quo_valid,
    output logic [QW-1:0] quo,
    output logic          ovf,
    output logic [SW-1:0] quo_side
);

    // Compare width: holds the numerator and the divisor at its largest shift.
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0] rem_reg   [0:QW];
    logic [DW-1:0] den_reg   [0:QW];
    logic [QW-1:0] quo_reg   [0:QW];
    logic          ovf_reg   [0:QW];
    logic          dz_reg    [0:QW];
    logic [SW-1:0] side_reg  [0:QW];
    logic          valid_reg [0:QW];

    logic [CW-1:0] den_top;

    // Entry stage: quotient overflow and zero divisor are decided up front.
    assign den_top = CW'(den) << QW;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= CW'(num);
            den_reg[0]  <= den;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= (den != '0) && (CW'(num) >= den_top);
            dz_reg[0]   <= (den == '0);
            side_reg[0] <= side;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= item_valid;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        localparam int SH = QW - k;
        logic [CW-1:0] dsh;
        logic          fits;

        assign dsh  = CW'(den_reg[k-1]) << SH;
        assign fits = rem_reg[k-1] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= fits ? (rem_reg[k-1] - dsh) : rem_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                quo_reg[k]  <= quo_reg[k-1] | (fits ? (QW'(1) << SH) : '0);
                ovf_reg[k]  <= ovf_reg[k-1];
                dz_reg[k]   <= dz_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // A zero divisor gives a zero quotient.
    assign quo_valid = valid_reg[QW];
    assign quo       = dz_reg[QW] ? '0 : quo_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign quo_side  = side_reg[QW];

endmodule

/* dv/tb.sv */
module tb;
    import tvdff_pkg::*;

    // One face of the flow path, as the block takes it on its input.
    typedef struct packed {
        logic signed [31:0] q_far;
        logic signed [31:0] c_far;
        logic signed [31:0] q_up;
        logic signed [31:0] c_up;
        logic signed [31:0] q_down;
        logic signed [31:0] c_down;
        logic [31:0]        len_far;
        logic [31:0]        len_up;
        logic [31:0]        len_down;
        logic               far_is_boundary;
        logic               face_is_downstream;
        logic [31:0]        scale;
    } face_t;

    typedef struct packed {
        logic signed [47:0] flux;
        logic               sat;
    } flux_t;

    // Work for the driver: a face, a limiter change, a pause, a long
    // receiver hold, or a change of gap rates.
    typedef enum int {ACT_FACE, ACT_LIMITER, ACT_DRAIN, ACT_HOLD, ACT_PACE} act_kind_t;

    typedef struct {
        act_kind_t   op;
        face_t       face;
        logic [2:0]  kind;
        int          in_gap;
        int          out_gap;
    } action_t;

    localparam longint ONE_Q = 65536;
    localparam longint TWO_Q = 131072;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [2:0]         cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] q_far;
    logic signed [31:0] c_far;
    logic signed [31:0] q_up;
    logic signed [31:0] c_up;
    logic signed [31:0] q_down;
    logic signed [31:0] c_down;
    logic [31:0]        len_far;
    logic [31:0]        len_up;
    logic [31:0]        len_down;
    logic               far_is_boundary;
    logic               face_is_downstream;
    logic [31:0]        scale;
    logic               out_valid;
    logic               out_stall;
    logic signed [47:0] face_flux;
    logic               flux_saturated;

    action_t pending[$];
    flux_t   flux_expected[$];
    face_t   face_on_bus;
    logic [2:0] limiter_now;
    bit      took;
    int      in_gap_pct;
    int      out_gap_pct;
    int      hold_left;
    int      mismatches;

    tvd_limited_face_flux_unit DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .q_far              (q_far),
        .c_far              (c_far),
        .q_up               (q_up),
        .c_up               (c_up),
        .q_down             (q_down),
        .c_down             (c_down),
        .len_far            (len_far),
        .len_up             (len_up),
        .len_down           (len_down),
        .far_is_boundary    (far_is_boundary),
        .face_is_downstream (face_is_downstream),
        .scale              (scale),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .face_flux          (face_flux),
        .flux_saturated     (flux_saturated)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] magn(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint lmin(longint a, longint b);
        return a < b ? a : b;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return a > b ? a : b;
    endfunction

    // Floor quotient clipped to a ceiling; a zero divisor yields zero.
    function automatic logic [63:0] clip_div(logic [127:0] n, logic [127:0] d,
                                            logic [63:0] cap);
        logic [127:0] q;
        if (d == 0)
            return 64'd0;
        q = n / d;
        return (q > 128'(cap)) ? cap : q[63:0];
    endfunction

    // Limiter function phi(r) in Q16.16.
    function automatic longint limit_phi(longint r, logic [2:0] kind);
        longint sq;
        longint n;
        longint q;
        case (kind)
            LIM_MINMOD:
                return lmax(0, lmin(r, ONE_Q));
            LIM_SUPERBEE:
                return lmax(0, lmax(lmin(2 * r, ONE_Q), lmin(r, TWO_Q)));
            LIM_VAN_LEER:
            begin
                if (r <= 0)
                    return 0;
                return longint'(clip_div(128'(2 * r) * 128'(ONE_Q), 128'(ONE_Q + r),
                                         64'(TWO_Q)));
            end
            LIM_MUSCL:
                return lmax(0, lmin(lmin(2 * r, (r + ONE_Q) / 2), TWO_Q));
            LIM_SWEBY:
                return lmax(0, lmax(lmin((3 * r) / 2, ONE_Q), lmin(r, (3 * ONE_Q) / 2)));
            LIM_VAN_ALBADA:
            begin
                // The sign of r(1 + r) survives, so the result is negative for r between -1 and 0.
                sq = r * r;
                n = r * ONE_Q + sq;
                q = longint'(clip_div(128'(magn(n)) * 128'(ONE_Q),
                                      128'(ONE_Q * ONE_Q + sq), 64'(TWO_Q)));
                return n < 0 ? -q : q;
            end
            LIM_QUICK:
                return lmax(0, lmin(lmin(2 * r, (3 * ONE_Q + r) / 4), TWO_Q));
            default:
                return lmax(0, lmin(lmin(2 * r, (ONE_Q + 3 * r) / 4),
                                    lmin((3 * ONE_Q + r) / 4, TWO_Q)));
        endcase
    endfunction

    // Expected limited flux of one face under the given limiter.
    function automatic flux_t face_flux_of(face_t f, logic [2:0] kind);
        longint pf;
        longint pu;
        longint pd;
        longint dfar;
        longint ddn;
        longint r;
        longint phi;
        longint term;
        longint fsum;
        logic [127:0] la;
        logic [127:0] lb;
        logic [63:0] tm;
        logic [63:0] fm;
        bit neg;
        flux_t res;
        pf = (longint'(f.q_far) * longint'(f.c_far)) >>> 16;
        pu = (longint'(f.q_up) * longint'(f.c_up)) >>> 16;
        pd = (longint'(f.q_down) * longint'(f.c_down)) >>> 16;
        dfar = pu - pf;
        ddn = pd - pu;
        la = 128'(f.len_up) + 128'(f.len_down);
        lb = f.far_is_boundary ? 128'(f.len_up) : 128'(f.len_up) + 128'(f.len_far);

        // Gradient ratio; a flat downwind gradient gives zero.
        r = longint'(clip_div(128'(magn(dfar)) * la * 128'(ONE_Q),
                              128'(magn(ddn)) * lb, 64'h7FFF_FFFF));
        if ((dfar < 0) != (ddn < 0))
            r = -r;
        phi = limit_phi(r, kind);

        // Interpolate toward the downwind cell.
        tm = clip_div(128'(magn(phi)) * 128'(magn(ddn)) * 128'(f.len_up),
                      la * 128'(ONE_Q), 64'd1 << 62);
        term = ((phi < 0) != (ddn < 0)) ? -longint'(tm) : longint'(tm);
        fsum = pu + term;

        // Scale, orient and saturate.
        fm = clip_div(128'(magn(fsum)) * 128'(f.scale), 128'(ONE_Q), 64'd1 << 48);
        neg = (fsum < 0) != f.face_is_downstream;
        if (fm == 0)
            neg = 0;
        res.sat = 0;
        if (neg)
        begin
            if (fm > (64'd1 << 47))
            begin
                fm = 64'd1 << 47;
                res.sat = 1;
            end
            res.flux = 48'(-longint'(fm));
        end
        else
        begin
            if (fm > (64'd1 << 47) - 1)
            begin
                fm = (64'd1 << 47) - 1;
                res.sat = 1;
            end
            res.flux = 48'(fm);
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_len();
        logic [31:0] v;
        if ($urandom_range(9) < 7)
            v = $urandom_range(32'h0010_0000, 32'h0000_4000);
        else
            v = $urandom;
        return v == 0 ? 32'd1 : v;
    endfunction

    // Mostly smooth profiles that give useful gradient ratios, with some noise.
    function automatic face_t rand_face();
        face_t f;
        int base;
        int d1;
        int d2;
        if ($urandom_range(9) < 7)
        begin
            base = $urandom_range(32'h0040_0000) - 32'h0020_0000;
            d1 = $urandom_range(32'h0004_0000) - 32'h0002_0000;
            d2 = ($urandom_range(7) == 0) ? 0 : $urandom_range(32'h0004_0000) - 32'h0002_0000;
            f.q_far = 32'sd65536 + $urandom_range(32'h4000) - 32'h2000;
            f.q_up = f.q_far + $urandom_range(32'h400) - 32'h200;
            f.q_down = ($urandom_range(3) == 0) ? f.q_up : f.q_up + $urandom_range(32'h400);
            f.c_far = base;
            f.c_up = base + d1;
            f.c_down = (f.q_down == f.q_up && d2 == 0) ? f.c_up : base + d1 + d2;
            f.scale = ($urandom_range(3) == 0) ? $urandom_range(32'h0080_0000) : 32'h0001_0000;
        end
        else
        begin
            f.q_far = $urandom;
            f.c_far = $urandom;
            f.q_up = $urandom;
            f.c_up = $urandom;
            f.q_down = $urandom;
            f.c_down = $urandom;
            f.scale = $urandom;
        end
        f.len_far = rand_len();
        f.len_up = rand_len();
        f.len_down = rand_len();
        f.far_is_boundary = 1'($urandom_range(1));
        f.face_is_downstream = 1'($urandom_range(1));
        return f;
    endfunction

    task automatic push_face(face_t f);
        action_t a;
        a.op = ACT_FACE;
        a.face = f;
        pending.push_back(a);
    endtask

    task automatic push_ctl(act_kind_t op, logic [2:0] kind, int in_gap, int out_gap);
        action_t a;
        a.op = op;
        a.face = '0;
        a.kind = kind;
        a.in_gap = in_gap;
        a.out_gap = out_gap;
        pending.push_back(a);
    endtask

    // Acceptance on both channels and the result check.
    always @(posedge clk)
    begin
        flux_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            flux_expected.push_back(face_flux_of(face_on_bus, limiter_now));
            took = 1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (flux_expected.size() == 0)
            begin
                $display("%0t: unexpected item flux=%0d sat=%0b", $time, face_flux,
                         flux_saturated);
                mismatches++;
            end
            else
            begin
                want = flux_expected.pop_front();
                if (want.flux !== face_flux)
                begin
                    $display("%0t: face_flux expected %0d actual %0d", $time, want.flux,
                             face_flux);
                    mismatches++;
                end
                if (want.sat !== flux_saturated)
                begin
                    $display("%0t: flux_saturated expected %0b actual %0b", $time, want.sat,
                             flux_saturated);
                    mismatches++;
                end
            end
        end
    end

    // Input driver, fed from the pending queue.
    always @(negedge clk)
    begin
        logic nv;
        logic nc;
        action_t a;
        if (rst_n)
        begin
            nv = in_valid && !took;
            nc = 0;
            if (!nv)
            begin
                took = 0;
                if (pending.size() != 0)
                begin
                    a = pending[0];
                    case (a.op)
                        ACT_FACE:
                        begin
                            if ($urandom_range(99) >= in_gap_pct)
                            begin
                                void'(pending.pop_front());
                                face_on_bus = a.face;
                                q_far <= a.face.q_far;
                                c_far <= a.face.c_far;
                                q_up <= a.face.q_up;
                                c_up <= a.face.c_up;
                                q_down <= a.face.q_down;
                                c_down <= a.face.c_down;
                                len_far <= a.face.len_far;
                                len_up <= a.face.len_up;
                                len_down <= a.face.len_down;
                                far_is_boundary <= a.face.far_is_boundary;
                                face_is_downstream <= a.face.face_is_downstream;
                                scale <= a.face.scale;
                                nv = 1;
                            end
                        end
                        ACT_LIMITER:
                        begin
                            // Only change the limiter with the pipeline empty.
                            if (flux_expected.size() == 0)
                            begin
                                void'(pending.pop_front());
                                cfg_data <= a.kind;
                                limiter_now = a.kind;
                                nc = 1;
                            end
                        end
                        ACT_DRAIN:
                        begin
                            if (flux_expected.size() == 0)
                                void'(pending.pop_front());
                        end
                        ACT_HOLD:
                        begin
                            void'(pending.pop_front());
                            hold_left = 400;
                        end
                        default:
                        begin
                            void'(pending.pop_front());
                            in_gap_pct = a.in_gap;
                            out_gap_pct = a.out_gap;
                        end
                    endcase
                end
            end
            in_valid <= nv;
            cfg_write <= nc;
        end
    end

    // Output stall, with an occasional long hold.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                out_stall <= 1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < out_gap_pct);
        end
    end

    initial
    begin
        face_t f;
        int k;
        int n;
        clk = 0;
        rst_n = 0;
        cfg_write = 0;
        cfg_data = LIM_MINMOD;
        in_valid = 0;
        out_stall = 0;
        q_far = 0;
        c_far = 0;
        q_up = 0;
        c_up = 0;
        q_down = 0;
        c_down = 0;
        len_far = 1;
        len_up = 1;
        len_down = 1;
        far_is_boundary = 0;
        face_is_downstream = 0;
        scale = 0;
        face_on_bus = '0;
        limiter_now = LIM_MINMOD;
        took = 0;
        in_gap_pct = 0;
        out_gap_pct = 0;
        hold_left = 0;
        mismatches = 0;

        // Directed faces under the reset limiter.
        f = '0;
        f.len_far = 1;
        f.len_up = 1;
        f.len_down = 1;
        push_face(f);
        f = '1;
        f.q_far = 32'h7FFF_FFFF;
        f.c_far = 32'h7FFF_FFFF;
        f.q_up = 32'h7FFF_FFFF;
        f.c_up = 32'h7FFF_FFFF;
        f.q_down = 32'h7FFF_FFFF;
        f.c_down = 32'h7FFF_FFFF;
        push_face(f);
        f.q_up = 32'h8000_0000;
        f.far_is_boundary = 0;
        push_face(f);
        f.face_is_downstream = 0;
        f.c_down = 32'h8000_0000;
        push_face(f);
        f = '0;
        f.q_far = 32'h8000_0000;
        f.c_far = 32'h8000_0000;
        f.q_up = 32'h8000_0000;
        f.c_up = 32'h7FFF_FFFF;
        f.q_down = 32'h8000_0000;
        f.c_down = 32'h8000_0000;
        f.len_far = 32'hFFFF_FFFF;
        f.len_up = 1;
        f.len_down = 32'hFFFF_FFFF;
        f.scale = 32'hFFFF_FFFF;
        f.face_is_downstream = 1;
        push_face(f);
        // Flat downwind gradient, boundary far point, and downstream faces.
        f.q_far = 32'sd65536;
        f.c_far = 32'sd131072;
        f.q_up = 32'sd65536;
        f.c_up = 32'sd262144;
        f.q_down = 32'sd65536;
        f.c_down = 32'sd262144;
        f.len_far = 32'h0001_0000;
        f.len_up = 32'h0001_0000;
        f.len_down = 32'h0002_0000;
        f.scale = 32'h0001_0000;
        f.face_is_downstream = 0;
        push_face(f);
        f.c_down = 32'sd393216;
        push_face(f);
        f.far_is_boundary = 1;
        push_face(f);
        f.face_is_downstream = 1;
        push_face(f);
        f.c_far = 32'sd524288;
        push_face(f);
        f.scale = 0;
        push_face(f);
        f.scale = 32'hFFFF_FFFF;
        f.c_up = 32'sh7000_0000;
        f.c_down = 32'sh7FFF_0000;
        push_face(f);
        f.face_is_downstream = 0;
        push_face(f);
        push_ctl(ACT_DRAIN, LIM_MINMOD, 0, 0);

        // Each limiter in turn, through three gap patterns.
        for (k = 0; k < 8; k++)
        begin
            push_ctl(ACT_LIMITER, 3'(k), 0, 0);
            if (k < 3)
                push_ctl(ACT_PACE, LIM_MINMOD, 38, 68);
            else if (k < 6)
                push_ctl(ACT_PACE, LIM_MINMOD, 68, 38);
            else
                push_ctl(ACT_PACE, LIM_MINMOD, 0, 0);
            for (n = 0; n < 242; n++)
            begin
                if (k == 6 && n == 40)
                    push_ctl(ACT_HOLD, LIM_MINMOD, 0, 0);
                if (k == 4 && n == 120)
                    push_ctl(ACT_DRAIN, LIM_MINMOD, 0, 0);
                push_face(rand_face());
            end
        end
        push_ctl(ACT_LIMITER, LIM_MINMOD, 0, 0);

        repeat (3) @(posedge clk);
        rst_n = 1;

        while (pending.size() != 0 || in_valid || flux_expected.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && flux_expected.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
